// File: rtl/ubdc_pkg.sv
// shared types and constants for the uart baud divisor calculator
// no dependencies; used by ubdc_div and uart_baud_divisor_calc_top
package ubdc_pkg;

    localparam int CLOCK_W = 28;
    localparam int BAUD_W  = 27;
    localparam int MANT_W  = 26;
    localparam int FRAC_W  = 4;
    localparam int WORD_W  = 30;

    localparam logic [CLOCK_W-1:0] CLOCK_RESET_HZ = 28'd16000000;

    // divider operands: (2*clock + baud) / (2*baud)
    localparam int NUM_W           = CLOCK_W + 2;
    localparam int DEN_W           = BAUD_W + 1;
    localparam int REM_W           = DEN_W;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = NUM_W / STEPS_PER_STAGE;

    localparam logic [FRAC_W-1:0] FRAC8_MASK  = 4'h7;
    localparam logic [FRAC_W-1:0] FRAC16_MASK = 4'hF;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_CLOCK_HZ = 1'b0;

    typedef struct packed {
        logic [BAUD_W-1:0] baud_rate;
        logic              oversample_by8;
    } t_req;

    typedef struct packed {
        logic              status;
        logic [MANT_W-1:0] mantissa;
        logic [FRAC_W-1:0] fraction;
        logic [WORD_W-1:0] divisor_word;
    } t_res;

    // side info that travels with each divide
    typedef struct packed {
        logic by8;
        logic err;
    } t_div_tag;

endpackage

// File: rtl/uart_baud_divisor_calc_top.sv
// uart fractional baud divisor: a request sampled with start passes the input register,
// the 15 stage divider pipe and the output register before o_valid shows its result
// throughput one request per clock; busy stays low, since nothing stalls the pipe
// the result strobe cannot be held off by the receiver
// synchronous active-low reset clears all valid bits and loads clock_hz with 16 MHz
// depends on ubdc_pkg and ubdc_div
module uart_baud_divisor_calc_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                start,
    output logic                                busy,
    input  ubdc_pkg::t_req                      i_req,
    // result channel
    output logic                                o_valid,
    output ubdc_pkg::t_res                      o_res,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [2:0]                          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    localparam int NW = ubdc_pkg::NUM_W;
    localparam int DW = ubdc_pkg::DEN_W;
    localparam int CW = ubdc_pkg::CLOCK_W;
    localparam int MW = ubdc_pkg::MANT_W;
    localparam int FW = ubdc_pkg::FRAC_W;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [CW-1:0] r_clock_hz;
    logic          w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= ubdc_pkg::CLOCK_RESET_HZ;
        end else if (w_cfg_wr && paddr[2] == ubdc_pkg::REG_CLOCK_HZ) begin
            r_clock_hz <= pwdata[CW-1:0];
        end
    end

    // writes beyond the list are dropped, reads there return zero
    always_comb begin
        if (paddr[2] == ubdc_pkg::REG_CLOCK_HZ) begin
            prdata = 32'(r_clock_hz);
        end else begin
            prdata = '0;
        end
    end

    // ------------------------------------------------------------------
    // input stage
    // the rounded value N = mant*factor + frac (carry included) equals
    // floor((2*clock + baud) / (2*baud)); mantissa and fraction are then
    // just the high and low bits of N
    // ------------------------------------------------------------------
    logic                 w_accept;
    logic                 r_in_vld;
    logic [NW-1:0]        r_num;
    logic [DW-1:0]        r_den;
    ubdc_pkg::t_div_tag   r_in_tag;

    // fully pipelined, a request is taken every cycle
    assign busy     = 1'b0;
    assign w_accept = start & ~busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_num        <= {1'b0, r_clock_hz, 1'b0} + NW'(i_req.baud_rate);
        r_den        <= {i_req.baud_rate, 1'b0};
        r_in_tag.by8 <= i_req.oversample_by8;
        r_in_tag.err <= (i_req.baud_rate == '0);
    end

    // ------------------------------------------------------------------
    // divider pipe
    // ------------------------------------------------------------------
    logic                 w_div_vld;
    logic [NW-1:0]        w_quot;
    ubdc_pkg::t_div_tag   w_div_tag;

    ubdc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_in_vld),
        .i_num   (r_num),
        .i_den   (r_den),
        .i_tag   (r_in_tag),
        .o_valid (w_div_vld),
        .o_quot  (w_quot),
        .o_tag   (w_div_tag)
    );

    // ------------------------------------------------------------------
    // result formatting and output register
    // ------------------------------------------------------------------
    logic                 r_out_vld;
    ubdc_pkg::t_res       r_res;
    ubdc_pkg::t_res       n_res;
    logic [MW-1:0]        w_mant;
    logic [FW-1:0]        w_frac;

    always_comb begin
        // 8x: fraction is the low 3 bits, 16x: the low 4 bits
        if (w_div_tag.by8) begin
            w_mant = MW'(w_quot >> 3);
            w_frac = w_quot[FW-1:0] & ubdc_pkg::FRAC8_MASK;
        end else begin
            w_mant = MW'(w_quot >> 4);
            w_frac = w_quot[FW-1:0] & ubdc_pkg::FRAC16_MASK;
        end

        if (w_div_tag.err) begin
            // zero baud rate: error status, all numbers zero
            n_res.status       = ubdc_pkg::STATUS_ERR;
            n_res.mantissa     = '0;
            n_res.fraction     = '0;
            n_res.divisor_word = '0;
        end else begin
            n_res.status       = ubdc_pkg::STATUS_OK;
            n_res.mantissa     = w_mant;
            n_res.fraction     = w_frac;
            n_res.divisor_word = {w_mant, w_frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= w_div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    // one cycle strobe per transfer
    assign o_valid = r_out_vld;
    assign o_res   = r_res;

endmodule

// File: rtl/ubdc_div.sv
// pipelined restoring divider, STEPS_PER_STAGE quotient bits per stage
// depends on ubdc_pkg
module ubdc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    input  logic [ubdc_pkg::NUM_W-1:0]  i_num,
    input  logic [ubdc_pkg::DEN_W-1:0]  i_den,
    input  ubdc_pkg::t_div_tag          i_tag,
    output logic                        o_valid,
    output logic [ubdc_pkg::NUM_W-1:0]  o_quot,
    output ubdc_pkg::t_div_tag          o_tag
);

    localparam int NW = ubdc_pkg::NUM_W;
    localparam int DW = ubdc_pkg::DEN_W;
    localparam int RW = ubdc_pkg::REM_W;
    localparam int NS = ubdc_pkg::DIV_STAGES;
    localparam int SP = ubdc_pkg::STEPS_PER_STAGE;

    logic                 r_vld  [NS];
    logic [RW-1:0]        r_rem  [NS];
    logic [NW-1:0]        r_num  [NS];
    logic [NW-1:0]        r_quot [NS];
    logic [DW-1:0]        r_den  [NS];
    ubdc_pkg::t_div_tag   r_tag  [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic                 a_vld;
        logic [RW-1:0]        a_rem;
        logic [NW-1:0]        a_num;
        logic [NW-1:0]        a_quot;
        logic [DW-1:0]        a_den;
        ubdc_pkg::t_div_tag   a_tag;
        logic [RW-1:0]        n_rem;
        logic [NW-1:0]        n_num;
        logic [NW-1:0]        n_quot;
        logic [RW:0]          w_shift;

        if (s == 0) begin : g_first
            assign a_vld  = i_valid;
            assign a_rem  = '0;
            assign a_num  = i_num;
            assign a_quot = '0;
            assign a_den  = i_den;
            assign a_tag  = i_tag;
        end else begin : g_next
            assign a_vld  = r_vld[s-1];
            assign a_rem  = r_rem[s-1];
            assign a_num  = r_num[s-1];
            assign a_quot = r_quot[s-1];
            assign a_den  = r_den[s-1];
            assign a_tag  = r_tag[s-1];
        end

        // SP dependent shift-compare-subtract steps
        always_comb begin
            n_rem   = a_rem;
            n_num   = a_num;
            n_quot  = a_quot;
            w_shift = '0;
            for (int k = 0; k < SP; k++) begin
                w_shift = {n_rem, n_num[NW-1]};
                n_num   = {n_num[NW-2:0], 1'b0};
                if (w_shift >= {1'b0, a_den}) begin
                    n_rem  = RW'(w_shift - {1'b0, a_den});
                    n_quot = {n_quot[NW-2:0], 1'b1};
                end else begin
                    n_rem  = w_shift[RW-1:0];
                    n_quot = {n_quot[NW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_num[s]  <= n_num;
            r_quot[s] <= n_quot;
            r_den[s]  <= a_den;
            r_tag[s]  <= a_tag;
        end
    end

    assign o_valid = r_vld[NS-1];
    assign o_quot  = r_quot[NS-1];
    assign o_tag   = r_tag[NS-1];

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// testbench for uart_baud_divisor_calc_top: directed and random divisor requests over
// several clock_hz settings, checked by a divisor predictor inside a small scoreboard
// depends on ubdc_pkg and the rtl top level
module tb;

    // start transfer edge to result edge, plus a little slack
    localparam int LATENCY    = 17;
    localparam int SETTLE     = LATENCY + 3;
    // cycles with no transfer of any kind before the run is declared hung
    localparam int IDLE_LIMIT = 5000;
    localparam int MAX_GAP    = 20;

    // register i sits at byte address 4*i, index taken from paddr[2]
    localparam logic [2:0] ADDR_CLOCK_HZ = {ubdc_pkg::REG_CLOCK_HZ, 2'b00};
    localparam logic [2:0] ADDR_UNUSED   = {~ubdc_pkg::REG_CLOCK_HZ, 2'b00};

    localparam logic [ubdc_pkg::BAUD_W-1:0] BAUD_MAX = '1;

    // holds the expected results still owed by the block, oldest first
    class divisor_scoreboard;
        ubdc_pkg::t_res               owed_q[$];
        logic [ubdc_pkg::CLOCK_W-1:0] clock_hz;
        int                           errors;

        function new();
            clock_hz = ubdc_pkg::CLOCK_RESET_HZ;
            errors   = 0;
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        // fractional divisor for one request at the current clock setting
        function ubdc_pkg::t_res divisor_of(ubdc_pkg::t_req req);
            ubdc_pkg::t_res res;
            logic [63:0]    factor;
            logic [63:0]    divider;
            logic [63:0]    mant;
            logic [63:0]    rem;
            logic [63:0]    frac;
            logic [63:0]    word;
            res = '0;
            if (req.baud_rate == '0) begin
                res.status = ubdc_pkg::STATUS_ERR;
                return res;
            end
            factor  = req.oversample_by8 ? 64'd8 : 64'd16;
            divider = factor * 64'(req.baud_rate);
            mant    = 64'(clock_hz) / divider;
            rem     = 64'(clock_hz) % divider;
            // round to nearest, a full step carries into the mantissa
            frac    = (rem * factor + (divider >> 1)) / divider;
            if (frac >= factor) begin
                mant = mant + 64'd1;
                frac = '0;
            end
            frac = frac & (req.oversample_by8 ? 64'(ubdc_pkg::FRAC8_MASK)
                                              : 64'(ubdc_pkg::FRAC16_MASK));
            word = (mant << 4) | frac;
            res.status       = ubdc_pkg::STATUS_OK;
            res.mantissa     = mant[ubdc_pkg::MANT_W-1:0];
            res.fraction     = frac[ubdc_pkg::FRAC_W-1:0];
            res.divisor_word = word[ubdc_pkg::WORD_W-1:0];
            return res;
        endfunction

        function void note_request(ubdc_pkg::t_req req);
            owed_q.push_back(divisor_of(req));
        endfunction

        task check_result(ubdc_pkg::t_res got);
            ubdc_pkg::t_res want;
            if (owed_q.size() == 0) begin
                report_mismatch($sformatf("result with nothing owed: %p", got));
                return;
            end
            want = owed_q.pop_front();
            if (got.status !== want.status)
                report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.mantissa !== want.mantissa)
                report_mismatch($sformatf("mantissa %0d, want %0d",
                                          got.mantissa, want.mantissa));
            if (got.fraction !== want.fraction)
                report_mismatch($sformatf("fraction %0d, want %0d",
                                          got.fraction, want.fraction));
            if (got.divisor_word !== want.divisor_word)
                report_mismatch($sformatf("divisor_word 0x%08h, want 0x%08h",
                                          got.divisor_word, want.divisor_word));
        endtask
    endclass

    logic           i_clk = 1'b0;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    ubdc_pkg::t_req i_req;
    logic           o_valid;
    ubdc_pkg::t_res o_res;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [2:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    divisor_scoreboard sb;
    // chance in percent that the sender idles in a given cycle
    int          sender_idle_pct;
    int          idle_cycles;

    always #5 i_clk = ~i_clk;

    uart_baud_divisor_calc_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // monitor: values are sampled before the edge's own updates land, so request
    // and result transfers are seen exactly as the block sees them
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                sb.note_request(i_req);
            end
            if (o_valid) begin
                sb.check_result(o_res);
            end
        end
    end

    // watchdog: any request, result or register transfer counts as progress
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || (psel && penable)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles with no transfer", idle_cycles);
            $display("uart_baud_divisor_calc_top test failed");
            $finish;
        end
    end

    // one request transfer, with a random idle gap ahead of it
    task automatic send_request(ubdc_pkg::t_req req);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < sender_idle_pct) gap++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= req;
        // start stays high until an edge sees busy low
        do @(posedge i_clk); while (busy);
    endtask

    task automatic send_baud(logic [ubdc_pkg::BAUD_W-1:0] baud, logic by8);
        ubdc_pkg::t_req req;
        req.baud_rate      = baud;
        req.oversample_by8 = by8;
        send_request(req);
    endtask

    // sender holds off until every owed result has come back
    task automatic wait_all_results();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.owed_q.size() != 0);
    endtask

    // register writes only happen with the pipe empty and settled
    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        wait_all_results();
        repeat (SETTLE) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic apb_read(logic [2:0] addr, output logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_clock_readback();
        logic [31:0] data;
        apb_read(ADDR_CLOCK_HZ, data);
        if (data !== {{(32-ubdc_pkg::CLOCK_W){1'b0}}, sb.clock_hz})
            sb.report_mismatch($sformatf("clock_hz read 0x%08h, want 0x%08h",
                                         data, sb.clock_hz));
    endtask

    // the block keeps only the low 28 bits of the written word
    task automatic set_clock(logic [31:0] data);
        apb_write(ADDR_CLOCK_HZ, data);
        sb.clock_hz = data[ubdc_pkg::CLOCK_W-1:0];
        check_clock_readback();
    endtask

    function automatic logic [31:0] pick_clock();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(7)) inside
            0, 1:    return r;
            2, 3:    return r >> $urandom_range(4, 24);
            4:       return 32'd48000000;
            5:       return 32'd1843200;
            6:       return 32'd100000000;
            default: return 32'd16000000;
        endcase
    endfunction

    function automatic ubdc_pkg::t_req random_request();
        ubdc_pkg::t_req req;
        logic [31:0]    r;
        int             sel;
        int             rates [12] = '{300, 1200, 2400, 9600, 19200, 38400, 57600,
                                       115200, 230400, 460800, 921600, 1000000};
        r   = $urandom;
        sel = $urandom_range(99);
        req.oversample_by8 = 1'($urandom_range(1));
        if (sel < 8) begin
            // rejected request
            req.baud_rate = '0;
        end else if (sel < 40) begin
            // full width, mostly divisor below one
            req.baud_rate = r[ubdc_pkg::BAUD_W-1:0];
        end else if (sel < 55) begin
            req.baud_rate = ubdc_pkg::BAUD_W'(rates[$urandom_range(11)]);
        end else begin
            // spread over magnitudes so the mantissa takes many sizes
            r = r >> $urandom_range(5, 31);
            req.baud_rate = (r[ubdc_pkg::BAUD_W-1:0] == '0) ? ubdc_pkg::BAUD_W'(1)
                                                              : r[ubdc_pkg::BAUD_W-1:0];
        end
        return req;
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        idle_cycles = 0;
        sb          = new();
        sender_idle_pct = 13;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of clock_hz
        check_clock_readback();

        // directed part at the 16 MHz reset clock
        send_baud('0, 1'b0);              // zero baud rate, error status
        send_baud('0, 1'b1);
        send_baud(ubdc_pkg::BAUD_W'(1), 1'b0);      // largest mantissa for this clock
        send_baud(ubdc_pkg::BAUD_W'(1), 1'b1);
        send_baud(BAUD_MAX, 1'b0);        // divisor below one
        send_baud(BAUD_MAX, 1'b1);
        send_baud(ubdc_pkg::BAUD_W'(115200), 1'b0);
        send_baud(ubdc_pkg::BAUD_W'(115200), 1'b1);
        send_baud(ubdc_pkg::BAUD_W'(9600), 1'b0);
        send_baud(ubdc_pkg::BAUD_W'(9600), 1'b1);
        send_baud(ubdc_pkg::BAUD_W'(1000000), 1'b0); // exact divide, zero fraction
        send_baud(ubdc_pkg::BAUD_W'(2000000), 1'b1);
        send_baud(ubdc_pkg::BAUD_W'(1000001), 1'b0); // fraction rounds up and carries
        send_baud(ubdc_pkg::BAUD_W'(2000001), 1'b1);

        // largest clock, written with the unused upper bits set
        set_clock(32'hFFFF_FFFF);
        send_baud(ubdc_pkg::BAUD_W'(1), 1'b0);
        send_baud(ubdc_pkg::BAUD_W'(1), 1'b1);
        send_baud(BAUD_MAX, 1'b0);
        send_baud(BAUD_MAX, 1'b1);
        send_baud(27'h555_5555, 1'b0);
        send_baud(27'h2AA_AAAA, 1'b1);

        // a write past the register list must leave clock_hz alone
        apb_write(ADDR_UNUSED, $urandom);
        check_clock_readback();

        // smallest clock, then a zero clock
        set_clock(32'd1);
        send_baud(ubdc_pkg::BAUD_W'(1), 1'b0);
        send_baud(ubdc_pkg::BAUD_W'(1), 1'b1);
        set_clock(32'd0);
        send_baud(ubdc_pkg::BAUD_W'(1), 1'b0);
        send_baud(ubdc_pkg::BAUD_W'(5), 1'b1);

        // random part: sender idles rarely, then often, then never
        for (int mode = 0; mode < 3; mode++) begin
            sender_idle_pct = (mode == 0) ? 13 : (mode == 1) ? 57 : 0;
            for (int chunk = 0; chunk < 3; chunk++) begin
                set_clock(pick_clock());
                for (int n = 0; n < 55; n++) begin
                    send_request(random_request());
                    // now and then let the pipe run dry mid-stream
                    if ($urandom_range(39) == 0) begin
                        wait_all_results();
                    end
                end
            end
        end

        // drain and give the pipe time to show any stray result
        wait_all_results();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.owed_q.size() != 0)
            sb.report_mismatch($sformatf("%0d results never came", sb.owed_q.size()));

        if (sb.errors == 0) begin
            $display("uart_baud_divisor_calc_top test passed");
        end else begin
            $display("uart_baud_divisor_calc_top test failed");
        end
        $finish;
    end

endmodule
